@@ hdl/command_line_edit_buffer_macros.svh @@
// assertion macros for the command line edit buffer
// used by the checker; no other dependencies
`ifndef COMMAND_LINE_EDIT_BUFFER_MACROS_SVH
`define COMMAND_LINE_EDIT_BUFFER_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define CLEB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under synchronous active-low reset
`define CLEB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/cleb_pkg.sv @@
// shared types and constants of the command line edit buffer
// no dependencies
package cleb_pkg;

    localparam int LINE_CAPACITY_DEF = 64;

    localparam int KIND_W = 3;
    localparam int CHAR_W = 8;
    localparam int RIDX_W = 6;
    localparam int LEN_W  = 7;

    // command codes; code 7 means nothing and is refused
    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT    = 3'd0,
        KIND_LEFT      = 3'd1,
        KIND_RIGHT     = 3'd2,
        KIND_DELETE    = 3'd3,
        KIND_BACKSPACE = 3'd4,
        KIND_CLEAR     = 3'd5,
        KIND_READ      = 3'd6
    } t_kind;

    typedef struct packed {
        logic              ok;
        logic [CHAR_W-1:0] char_out;
        logic [LEN_W-1:0]  line_length;
        logic [LEN_W-1:0]  cursor_out;
    } t_result;

endpackage

@@ hdl/cleb_if.sv @@
// command and result channels of the command line edit buffer
// depends on cleb_pkg
interface cleb_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [cleb_pkg::KIND_W-1:0] kind;
    logic [cleb_pkg::CHAR_W-1:0] char_in;
    logic [cleb_pkg::RIDX_W-1:0] read_index;

    modport source  (output valid, kind, char_in, read_index, input ready);
    modport sink    (input valid, kind, char_in, read_index, output ready);
endinterface

interface cleb_res_if;
    logic                        valid;
    logic                        ready;
    logic                        ok;
    logic [cleb_pkg::CHAR_W-1:0] char_out;
    logic [cleb_pkg::LEN_W-1:0]  line_length;
    logic [cleb_pkg::LEN_W-1:0]  cursor_out;

    modport source  (output valid, ok, char_out, line_length, cursor_out, input ready);
    modport sink    (input valid, ok, char_out, line_length, cursor_out, output ready);
endinterface

@@ hdl/cleb_line_ram.sv @@
// line byte store: one write port, one read port with registered data
// depends on cleb_pkg
module cleb_line_ram #(
    parameter int DEPTH = cleb_pkg::LINE_CAPACITY_DEF,
    parameter int AW    = $clog2(cleb_pkg::LINE_CAPACITY_DEF)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [cleb_pkg::CHAR_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [cleb_pkg::CHAR_W-1:0] o_rdata
);

    logic [cleb_pkg::CHAR_W-1:0] r_mem [DEPTH];
    logic [cleb_pkg::CHAR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/cleb_addr_unit.sv @@
// shared address stepper: next address up or down and end-of-walk compare
// depends on nothing but its parameter
module cleb_addr_unit #(
    parameter int AW = 6
) (
    input  logic [AW-1:0] i_addr,
    input  logic [AW-1:0] i_last,
    input  logic          i_up,
    output logic [AW-1:0] o_next,
    output logic          o_hit
);

    // wraps past either end only on the final step, whose result is unused
    assign o_next = i_up ? (i_addr + AW'(1)) : (i_addr - AW'(1));
    assign o_hit  = (i_addr == i_last);

endmodule

@@ hdl/cleb_ctrl.sv @@
// command sequencer: decodes a word, walks the shift loop, reads bytes
// depends on cleb_pkg, cleb_addr_unit, cleb_line_ram
module cleb_ctrl #(
    parameter int LINE_CAPACITY = cleb_pkg::LINE_CAPACITY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    output logic                        o_cmd_ready,
    input  logic [cleb_pkg::KIND_W-1:0] i_kind,
    input  logic [cleb_pkg::CHAR_W-1:0] i_char_in,
    input  logic [cleb_pkg::RIDX_W-1:0] i_read_index,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output cleb_pkg::t_result           o_res
);

    localparam int AW = $clog2(LINE_CAPACITY);
    localparam int CW = $clog2(LINE_CAPACITY + 1);
    localparam int LW = cleb_pkg::LEN_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT,
        S_DRAIN,
        S_PUT,
        S_RDWAIT,
        S_DONE
    } t_state;

    t_state                      r_state;
    cleb_pkg::t_kind             r_kind;
    logic [cleb_pkg::CHAR_W-1:0] r_char;
    logic [cleb_pkg::RIDX_W-1:0] r_ridx;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               r_cursor;
    logic [AW-1:0]               r_src;
    logic [AW-1:0]               r_dst;
    logic [AW-1:0]               r_wa;
    logic [AW-1:0]               r_last;
    logic                        r_up;
    logic                        r_pend;
    logic                        r_ok;
    logic [cleb_pkg::CHAR_W-1:0] r_cout;

    logic [AW-1:0]               addr_next;
    logic                        addr_hit;
    logic                        read_hit;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [cleb_pkg::CHAR_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [cleb_pkg::CHAR_W-1:0] ram_rdata;

    cleb_addr_unit #(
        .AW (AW)
    ) u_addr (
        .i_addr (r_src),
        .i_last (r_last),
        .i_up   (r_up),
        .o_next (addr_next),
        .o_hit  (addr_hit)
    );

    cleb_line_ram #(
        .DEPTH (LINE_CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign read_hit = (LW'(r_ridx) < LW'(r_count));

    always_comb begin
        ram_re    = (r_state == S_SHIFT) ||
                    ((r_state == S_EXEC) && (r_kind == cleb_pkg::KIND_READ) && read_hit);
        ram_raddr = (r_state == S_SHIFT) ? r_src : AW'(r_ridx);
        ram_we    = ((r_state == S_SHIFT) && r_pend) || (r_state == S_DRAIN) ||
                    (r_state == S_PUT);
        ram_waddr = (r_state == S_PUT) ? AW'(r_cursor) : r_wa;
        ram_wdata = (r_state == S_PUT) ? r_char : ram_rdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cursor <= '0;
            r_pend   <= 1'b0;
            r_ok     <= 1'b0;
            r_cout   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_kind  <= cleb_pkg::t_kind'(i_kind);
                        r_char  <= i_char_in;
                        r_ridx  <= i_read_index;
                        r_ok    <= 1'b0;
                        r_cout  <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_DONE;
                    unique case (r_kind)
                        cleb_pkg::KIND_INSERT: begin
                            if (r_count < CW'(LINE_CAPACITY)) begin
                                if (r_cursor == r_count) begin
                                    r_state <= S_PUT;
                                end else begin
                                    r_src   <= AW'(r_count - CW'(1));
                                    r_dst   <= AW'(r_count);
                                    r_last  <= AW'(r_cursor);
                                    r_up    <= 1'b0;
                                    r_state <= S_SHIFT;
                                end
                            end
                        end
                        cleb_pkg::KIND_LEFT: begin
                            if (r_cursor != '0) begin
                                r_cursor <= r_cursor - CW'(1);
                                r_ok     <= 1'b1;
                            end
                        end
                        cleb_pkg::KIND_RIGHT: begin
                            if (r_cursor < r_count) begin
                                r_cursor <= r_cursor + CW'(1);
                                r_ok     <= 1'b1;
                            end
                        end
                        cleb_pkg::KIND_DELETE: begin
                            if (r_cursor < r_count) begin
                                r_ok    <= 1'b1;
                                r_count <= r_count - CW'(1);
                                if ((r_cursor + CW'(1)) != r_count) begin
                                    r_src   <= AW'(r_cursor + CW'(1));
                                    r_dst   <= AW'(r_cursor);
                                    r_last  <= AW'(r_count - CW'(1));
                                    r_up    <= 1'b1;
                                    r_state <= S_SHIFT;
                                end
                            end
                        end
                        cleb_pkg::KIND_BACKSPACE: begin
                            if (r_cursor != '0) begin
                                r_ok     <= 1'b1;
                                r_count  <= r_count - CW'(1);
                                r_cursor <= r_cursor - CW'(1);
                                if (r_cursor != r_count) begin
                                    r_src   <= AW'(r_cursor);
                                    r_dst   <= AW'(r_cursor - CW'(1));
                                    r_last  <= AW'(r_count - CW'(1));
                                    r_up    <= 1'b1;
                                    r_state <= S_SHIFT;
                                end
                            end
                        end
                        cleb_pkg::KIND_CLEAR: begin
                            r_count  <= '0;
                            r_cursor <= '0;
                            r_ok     <= 1'b1;
                        end
                        cleb_pkg::KIND_READ: begin
                            if (read_hit) begin
                                r_ok    <= 1'b1;
                                r_state <= S_RDWAIT;
                            end
                        end
                        default: begin
                            r_ok <= 1'b0;
                        end
                    endcase
                end
                S_SHIFT: begin
                    // read at src, write the previous read one slot over
                    r_wa   <= r_dst;
                    r_dst  <= r_src;
                    r_src  <= addr_next;
                    r_pend <= 1'b1;
                    if (addr_hit) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_pend  <= 1'b0;
                    r_state <= (r_kind == cleb_pkg::KIND_INSERT) ? S_PUT : S_DONE;
                end
                S_PUT: begin
                    r_count  <= r_count + CW'(1);
                    r_cursor <= r_cursor + CW'(1);
                    r_ok     <= 1'b1;
                    r_state  <= S_DONE;
                end
                S_RDWAIT: begin
                    r_cout  <= ram_rdata;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cmd_ready          = (r_state == S_IDLE);
    assign o_res_valid          = (r_state == S_DONE);
    assign o_res.ok             = r_ok;
    assign o_res.char_out       = r_cout;
    assign o_res.line_length    = LW'(r_count);
    assign o_res.cursor_out     = LW'(r_cursor);

endmodule

@@ hdl/command_line_edit_buffer.sv @@
// top level of the command line edit buffer: sequencer plus result register
// depends on cleb_pkg, cleb_if, cleb_ctrl
//
//  channel  | dir | payload                              | handshake
//  ---------+-----+--------------------------------------+------------------
//  i_cmd    | in  | kind, char_in, read_index            | valid & ready
//  o_res    | out | ok, char_out, line_length, cursor_out| valid & ready
//
// steps: each command goes from idle through exec to done; a read adds a wait
// for the registered byte; delete and backspace add a walk of k bytes through
// the line store, one slot per cycle (k at most LINE_CAPACITY - 1), and a
// drain; insert adds the same walk and drain and then a put of the new byte;
// with nothing to move the walk and drain are skipped; the next word is taken
// once the result has moved into the output register
// reset: synchronous, active low; clears length, cursor and all valid flags,
// line bytes are left as they are
// stalls: a held result does not block the next word, only the one after it
module command_line_edit_buffer #(
    parameter int LINE_CAPACITY = cleb_pkg::LINE_CAPACITY_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cleb_cmd_if.sink        i_cmd,
    cleb_res_if.source      o_res
);

    cleb_pkg::t_result r_out;
    logic              r_out_valid;

    cleb_pkg::t_result res;
    logic              res_valid;
    logic              res_ready;

    // the sequencer hands over when the output register is empty or draining
    assign res_ready = !r_out_valid || o_res.ready;

    cleb_ctrl #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (i_cmd.valid),
        .o_cmd_ready  (i_cmd.ready),
        .i_kind       (i_cmd.kind),
        .i_char_in    (i_cmd.char_in),
        .i_read_index (i_cmd.read_index),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res)
    );

    // output register parts the result side from the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.ok          = r_out.ok;
    assign o_res.char_out    = r_out.char_out;
    assign o_res.line_length = r_out.line_length;
    assign o_res.cursor_out  = r_out.cursor_out;

endmodule

@@ hdl/cleb_checker.sv @@
// port-level checks of the command line edit buffer, bound to the top level
// depends on cleb_pkg and command_line_edit_buffer_macros.svh
`include "command_line_edit_buffer_macros.svh"

module cleb_checker #(
    parameter int LINE_CAPACITY = cleb_pkg::LINE_CAPACITY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    input  logic                        i_cmd_ready,
    input  logic                        i_res_valid,
    input  logic                        i_res_ready,
    input  logic                        i_ok,
    input  logic [cleb_pkg::CHAR_W-1:0] i_char_out,
    input  logic [cleb_pkg::LEN_W-1:0]  i_line_length,
    input  logic [cleb_pkg::LEN_W-1:0]  i_cursor_out
);

    localparam int LW = cleb_pkg::LEN_W;

    logic [cleb_pkg::CHAR_W+2*LW:0] res_word;

    assign res_word = {i_ok, i_char_out, i_line_length, i_cursor_out};

    // a stalled result word holds
    `CLEB_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready,
        i_res_valid && $stable(res_word), "result word changed under stall")

    // no command is taken in the cycle after one is taken
    `CLEB_ASSERT_NXT(a_busy, i_clk, i_rst_n, i_cmd_valid && i_cmd_ready, !i_cmd_ready,
        "command taken on back-to-back cycles")

    `CLEB_ASSERT_IMP(a_cursor, i_clk, i_rst_n, i_res_valid, i_cursor_out <= i_line_length,
        "cursor beyond line end")

    `CLEB_ASSERT_IMP(a_cap, i_clk, i_rst_n, i_res_valid, i_line_length <= LW'(LINE_CAPACITY),
        "line longer than capacity")

    // only a successful read carries a byte
    `CLEB_ASSERT_IMP(a_char, i_clk, i_rst_n, i_res_valid && (i_char_out != '0), i_ok,
        "byte returned by a refused command")

endmodule

bind command_line_edit_buffer cleb_checker #(
    .LINE_CAPACITY (LINE_CAPACITY)
) u_cleb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cmd_valid   (i_cmd.valid),
    .i_cmd_ready   (i_cmd.ready),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_ok          (o_res.ok),
    .i_char_out    (o_res.char_out),
    .i_line_length (o_res.line_length),
    .i_cursor_out  (o_res.cursor_out)
);
